FILE: design/hmsd_pkg.sv
// hmsd_pkg: shared types, widths and register codes for the hand motion stop detector.
// No dependencies; every other design file uses it.
package hmsd_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int CNT_BITS   = 16;
	localparam int CFG_BITS   = 16;
	localparam int IDX_BITS   = 2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [CNT_BITS-1:0]          count_t;
	typedef logic [FRAC_BITS-1:0]         frac_t;
	typedef logic [CFG_BITS-1:0]          cfg_word_t;
	typedef logic [IDX_BITS-1:0]          cfg_idx_t;

	// register indexes of the configuration port
	localparam cfg_idx_t CFG_WARMUP_FRAMES   = 2'd0;
	localparam cfg_idx_t CFG_MARGIN_FRACTION = 2'd1;
	localparam cfg_idx_t CFG_STILL_LIMIT     = 2'd2;

	localparam count_t RST_WARMUP_FRAMES   = 16'd30;
	localparam frac_t  RST_MARGIN_FRACTION = 16'd3277;
	localparam count_t RST_STILL_LIMIT     = 16'd30;

	typedef struct packed {
		count_t warmup_frames;
		frac_t  margin_fraction;
		count_t still_limit;
	} cfg_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} pos_t;

	typedef struct packed {
		logic   en;
		pos_t   pos;
	} step_t;

	typedef struct packed {
		logic   stopped;
		count_t still_count;
	} res_t;

endpackage

FILE: design/hmsd_pos_if.sv
// hmsd_pos_if: valid/ready channel carrying one hand position beat.
// Depends on hmsd_pkg for the coordinate type.
interface hmsd_pos_if;
	logic               valid;
	logic               ready;
	hmsd_pkg::coord_t   pos_x;
	hmsd_pkg::coord_t   pos_y;
	hmsd_pkg::coord_t   pos_z;

	modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
	modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

FILE: design/hmsd_res_if.sv
// hmsd_res_if: valid/ready channel carrying one stop detection result beat.
// Depends on hmsd_pkg for the counter type.
interface hmsd_res_if;
	logic               valid;
	logic               ready;
	logic               stopped;
	hmsd_pkg::count_t   still_count;

	modport source (output valid, output stopped, output still_count, input ready);
	modport sink   (input valid, input stopped, input still_count, output ready);
endinterface

FILE: design/hmsd_axis.sv
// hmsd_axis: motion test on one axis, |cur - prev| * 2^16 >= |prev| * fraction, exact.
// Depends on hmsd_pkg.
module hmsd_axis (
	input  hmsd_pkg::coord_t cur,
	input  hmsd_pkg::coord_t prev,
	input  hmsd_pkg::frac_t  frac,
	output logic             moved
);
	import hmsd_pkg::*;

	localparam int CMP_BITS = COORD_BITS + FRAC_BITS + 1;

	logic signed [COORD_BITS:0]   diff;
	logic        [COORD_BITS:0]   diff_mag;
	logic        [COORD_BITS-1:0] prev_mag;
	logic        [CMP_BITS-1:0]   change;
	logic        [COORD_BITS+FRAC_BITS-1:0] margin;

	assign diff     = {cur[COORD_BITS-1], cur} - {prev[COORD_BITS-1], prev};
	assign diff_mag = diff[COORD_BITS] ? (COORD_BITS+1)'(0) - diff : diff;
	// most negative prev wraps to its magnitude as an unsigned pattern
	assign prev_mag = prev[COORD_BITS-1] ? COORD_BITS'(0) - prev : prev;
	assign change   = {diff_mag, {FRAC_BITS{1'b0}}};
	assign margin   = prev_mag * frac;
	assign moved    = change >= {1'b0, margin};
endmodule

FILE: design/hmsd_track.sv
// hmsd_track: previous position, warm-up and stillness counters, per-beat decision.
// Depends on hmsd_pkg and hmsd_axis.
module hmsd_track (
	input  logic           clk,
	input  logic           arst_n,
	input  hmsd_pkg::cfg_t  cfg,
	input  hmsd_pkg::step_t step,
	output hmsd_pkg::res_t  res
);
	import hmsd_pkg::*;

	coord_t prev_x_q, prev_y_q, prev_z_q;
	count_t warm_q, still_q;
	count_t warm_d, still_d;
	logic   mx, my, mz, moved, stop;

	hmsd_axis u_ax_x (.cur(step.pos.x), .prev(prev_x_q), .frac(cfg.margin_fraction), .moved(mx));
	hmsd_axis u_ax_y (.cur(step.pos.y), .prev(prev_y_q), .frac(cfg.margin_fraction), .moved(my));
	hmsd_axis u_ax_z (.cur(step.pos.z), .prev(prev_z_q), .frac(cfg.margin_fraction), .moved(mz));

	assign moved = mx | my | mz;

	always_comb begin
		warm_d  = warm_q;
		still_d = still_q;
		stop    = 1'b0;
		if (warm_q < cfg.warmup_frames) begin
			warm_d = warm_q + 1'b1;
		end else if (moved) begin
			if (still_q != '0) begin
				still_d = still_q - 1'b1;
			end
		end else if (still_q < cfg.still_limit) begin
			still_d = still_q + 1'b1;
		end else begin
			stop = 1'b1;
		end
	end

	assign res.stopped     = stop;
	assign res.still_count = still_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_z_q <= '0;
			warm_q   <= '0;
			still_q  <= '0;
		end else if (step.en) begin
			prev_x_q <= step.pos.x;
			prev_y_q <= step.pos.y;
			prev_z_q <= step.pos.z;
			warm_q   <= warm_d;
			still_q  <= still_d;
		end
	end
endmodule

FILE: design/hand_motion_stop_detector.sv
// hand_motion_stop_detector: top level; config registers, input and result registers.
// Depends on hmsd_pkg, hmsd_pos_if, hmsd_res_if and hmsd_track.
//
//   channel   dir   beat payload                  width
//   pos_in    in    pos_x, pos_y, pos_z (signed)  3 x 16
//   res_out   out   stopped, still_count          1 + 16
//   cfg_*     in    cfg_index, cfg_data (write)   2 + 16
//
// One position beat is taken per cycle while pos_in.ready is high; its result
// passes through the input register, then the result register, before res_out
// offers it. The per-beat path is three parallel 16x16 margin multiplies,
// a compare and the counter update.
// Reset clears the previous position and both counters and loads the
// register defaults (30, 3277, 30).
// A stalled result holds in the result register; the input register can still
// take one beat while it is empty, then pos_in.ready drops.
module hand_motion_stop_detector (
	input  logic                 clk,
	input  logic                 arst_n,
	hmsd_pos_if.sink             pos_in,
	hmsd_res_if.source           res_out,
	input  logic                 cfg_we,
	input  hmsd_pkg::cfg_idx_t   cfg_index,
	input  hmsd_pkg::cfg_word_t  cfg_data
);
	import hmsd_pkg::*;

	cfg_t  cfg_q;
	pos_t  pos_s1;
	logic  valid_s1;
	res_t  res_s2;
	logic  valid_s2;
	logic  advance;
	step_t step;
	res_t  res;

	// configuration: writes to unused indexes fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.warmup_frames   <= RST_WARMUP_FRAMES;
			cfg_q.margin_fraction <= RST_MARGIN_FRACTION;
			cfg_q.still_limit     <= RST_STILL_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WARMUP_FRAMES:   cfg_q.warmup_frames   <= cfg_data;
				CFG_MARGIN_FRACTION: cfg_q.margin_fraction <= cfg_data;
				CFG_STILL_LIMIT:     cfg_q.still_limit     <= cfg_data;
				default: ;
			endcase
		end
	end

	// result register free or draining this cycle
	assign advance      = !valid_s2 || res_out.ready;
	assign pos_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pos_in.ready) begin
			valid_s1 <= pos_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pos_in.ready && pos_in.valid) begin
			pos_s1.x <= pos_in.pos_x;
			pos_s1.y <= pos_in.pos_y;
			pos_s1.z <= pos_in.pos_z;
		end
	end

	// state moves exactly when the staged beat passes into the result register
	assign step.en  = valid_s1 && advance;
	assign step.pos = pos_s1;

	hmsd_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.step   (step),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step.en) begin
			res_s2 <= res;
		end
	end

	assign res_out.valid       = valid_s2;
	assign res_out.stopped     = res_s2.stopped;
	assign res_out.still_count = res_s2.still_count;

`ifndef NO_ASSERTIONS
	a_stop_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.stopped |-> res_s2.still_count >= cfg_q.still_limit)
		else $error("stop reported below the still limit");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> pos_in.ready)
		else $error("input stage empty but not ready");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(pos_s1))
		else $error("staged beat lost during stall");

	a_step_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		step.en |=> valid_s2)
		else $error("state advanced without a result");
`endif
endmodule

FILE: verif/hand_motion_stop_detector_tb.sv
// hand_motion_stop_detector_tb: self-checking bench for the hand motion stop detector.
// Depends on hmsd_pkg, hmsd_pos_if, hmsd_res_if and the hand_motion_stop_detector RTL.
// Positions are driven from a queue, predicted on acceptance and checked in order.
`timescale 1ns / 1ps

module hand_motion_stop_detector_tb;
	import hmsd_pkg::*;

	// index 3 is decoded by nothing; writes there must leave every register alone
	localparam cfg_idx_t CFG_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 2000;   // idle cycles before the run is declared hung
	localparam int HOLD_CYCLES = 64;     // long receiver hold-off, fills the pipe
	localparam int PHASE_FRAMES = 140;   // position beats per random phase

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_index;
	cfg_word_t cfg_data;

	hmsd_pos_if pos_bus ();
	hmsd_res_if res_bus ();

	hand_motion_stop_detector uut (
		.clk(clk),
		.arst_n(arst_n),
		.pos_in(pos_bus),
		.res_out(res_bus),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// positions waiting to be offered, results waiting to come back
	pos_t frames_in [$];
	res_t expect_q [$];

	// tracker copy: registers, last position, warm-up and stillness counters
	cfg_t cfg;
	pos_t last_pos;
	count_t warm_seen;
	count_t still_run;

	int errors = 0;
	int res_beats = 0;
	int quiet_cycles = 0;
	int hold_left;
	bit hold_done;
	bit gaps_on = 1'b1;   // random idling on both channels
	bit hold_req = 1'b0;  // asks the monitor for one long hold-off
	res_t want_res;

	// Motion on one axis: |cur - last| * 2^16 >= |last| * fraction, exact, no rounding.
	// A zero last coordinate or zero fraction gives a zero margin, so the axis always moves.
	function automatic logic axis_moving(coord_t cur, coord_t last);
		logic signed [COORD_BITS:0] delta;
		logic [COORD_BITS:0] dmag;
		logic [COORD_BITS:0] lmag;
		logic [COORD_BITS+FRAC_BITS:0] travel;
		logic [COORD_BITS+FRAC_BITS:0] margin;
		delta = cur - last;
		dmag = delta[COORD_BITS] ? -delta : delta;
		lmag = (last < 0) ? -last : last;
		travel = {dmag, {FRAC_BITS{1'b0}}};
		margin = lmag * cfg.margin_fraction;
		return travel >= margin;
	endfunction

	// One frame through the tracker: returns the result it must produce.
	function automatic res_t track_frame(pos_t cur);
		res_t r;
		logic moving;
		r.stopped = 1'b0;
		if (warm_seen < cfg.warmup_frames) begin
			// warm-up: stillness frozen, never stopped
			warm_seen++;
		end else begin
			moving = axis_moving(cur.x, last_pos.x) || axis_moving(cur.y, last_pos.y) ||
				axis_moving(cur.z, last_pos.z);
			if (moving) begin
				if (still_run != 0)
					still_run--;
			end else if (still_run < cfg.still_limit) begin
				still_run++;
			end else begin
				// at or above the limit (also when the limit was lowered): hold and flag
				r.stopped = 1'b1;
			end
		end
		last_pos = cur;
		r.still_count = still_run;
		return r;
	endfunction

	function automatic void offer(coord_t x, coord_t y, coord_t z);
		pos_t p;
		p.x = x;
		p.y = y;
		p.z = z;
		frames_in.push_back(p);
	endfunction

	// base plus a random offset in [-spread, spread], clipped to the coordinate range
	function automatic coord_t near(coord_t base, int spread);
		int v;
		v = int'(base) + int'($urandom_range(2 * spread)) - spread;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return coord_t'(v);
	endfunction

	// Register write; only called with nothing in flight, so the tracker copy
	// can follow right away.
	task automatic write_reg(cfg_idx_t idx, cfg_word_t val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_WARMUP_FRAMES: cfg.warmup_frames = val;
			CFG_MARGIN_FRACTION: cfg.margin_fraction = val;
			CFG_STILL_LIMIT: cfg.still_limit = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every queued position went in and every result came back
	task automatic drain();
		while (frames_in.size() != 0 || expect_q.size() != 0)
			@(negedge clk);
	endtask

	// A hand resting near a random anchor: jitter is a quarter of the margin,
	// so most frames are still and the counter climbs toward the limit.
	task automatic rest_run(int frames);
		int spread [3];
		coord_t anchor [3];
		int mag;
		for (int a = 0; a < 3; a++) begin
			mag = $urandom_range(32767, 256);
			anchor[a] = $urandom_range(1) ? coord_t'(-mag) : coord_t'(mag);
			spread[a] = int'((longint'(mag) * cfg.margin_fraction) >> 18);
		end
		repeat (frames)
			offer(near(anchor[0], spread[0]), near(anchor[1], spread[1]),
				near(anchor[2], spread[2]));
	endtask

	// Mostly rest runs (the only way to reach stop), some sweeps, some noise.
	task automatic random_phase(cfg_word_t warm, cfg_word_t frac, cfg_word_t limit);
		int made;
		int len;
		int pick;
		write_reg(CFG_WARMUP_FRAMES, warm);
		write_reg(CFG_MARGIN_FRACTION, frac);
		write_reg(CFG_STILL_LIMIT, limit);
		made = 0;
		while (made < PHASE_FRAMES) begin
			pick = $urandom_range(99);
			if (pick < 65) begin
				len = $urandom_range(45, 2);
				rest_run(len);
			end else if (pick < 88) begin
				// hand sweeping through the middle of the space
				len = $urandom_range(6, 1);
				repeat (len)
					offer(coord_t'(int'($urandom_range(8000)) - 4000),
						coord_t'(int'($urandom_range(8000)) - 4000),
						coord_t'(int'($urandom_range(8000)) - 4000));
			end else begin
				// tracking glitches: any 16 bit pattern
				len = $urandom_range(3, 1);
				repeat (len)
					offer(coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()));
			end
			made += len;
		end
	endtask

	// Driver: offers the head of frames_in, holds it while stalled, predicts on the beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_bus.valid <= 1'b0;
			pos_bus.pos_x <= '0;
			pos_bus.pos_y <= '0;
			pos_bus.pos_z <= '0;
		end else begin
			if (pos_bus.valid && pos_bus.ready)
				expect_q.push_back(track_frame(frames_in.pop_front()));
			if (pos_bus.valid && !pos_bus.ready) begin
				// stalled: keep the beat as it is
			end else if (frames_in.size() != 0 && !(gaps_on && $urandom_range(99) < 14)) begin
				pos_bus.valid <= 1'b1;
				pos_bus.pos_x <= frames_in[0].x;
				pos_bus.pos_y <= frames_in[0].y;
				pos_bus.pos_z <= frames_in[0].z;
			end else begin
				pos_bus.valid <= 1'b0;
			end
		end
	end

	// Monitor: checks each result beat against the oldest prediction, drives ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				res_beats++;
				if (expect_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("beat %0d: result with nothing expected (stopped %0b count %0d)",
							res_beats, res_bus.stopped, res_bus.still_count);
				end else begin
					want_res = expect_q.pop_front();
					if (res_bus.stopped !== want_res.stopped ||
							res_bus.still_count !== want_res.still_count) begin
						errors++;
						if (errors <= 10)
							$display("beat %0d: stopped exp %0b got %0b, still_count exp %0d got %0d",
								res_beats, want_res.stopped, res_bus.stopped,
								want_res.still_count, res_bus.still_count);
					end
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				res_bus.ready <= 1'b0;
			end else if (hold_req && !hold_done) begin
				// sender keeps going while we refuse: both registers fill, input stalls
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= !(gaps_on && $urandom_range(99) < 14);
			end
		end
	end

	// Watchdog: too long without any beat on either channel means a hang.
	always @(posedge clk) begin
		if ((pos_bus.valid && pos_bus.ready) || (res_bus.valid && res_bus.ready))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_WARMUP_FRAMES;
		cfg_data = '0;
		cfg.warmup_frames = RST_WARMUP_FRAMES;
		cfg.margin_fraction = RST_MARGIN_FRACTION;
		cfg.still_limit = RST_STILL_LIMIT;
		last_pos = '0;
		warm_seen = '0;
		still_run = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset defaults: 30 warm-up frames, then a resting hand
		rest_run(45);
		drain();

		// Directed: limit below the counter, margin boundary, coordinate extremes,
		// zero previous position, and the unused register index.
		write_reg(CFG_STILL_LIMIT, 16'd2);
		write_reg(CFG_WARMUP_FRAMES, 16'd0);
		write_reg(CFG_UNUSED, 16'hFFFF);
		write_reg(CFG_UNUSED, 16'h0000);
		@(negedge clk);
		offer(20000, 20000, 20000);
		offer(20000, 20000, 20000);
		offer(21000, 20000, 20000);   // change just under the margin
		offer(22051, 20000, 20000);   // change just over the margin
		offer(32767, 32767, 32767);
		offer(32767, 32767, 32767);
		offer(-32768, -32768, -32768);
		offer(-32768, -32768, -32768);
		offer(32767, -32768, 0);
		offer(0, 0, 0);
		offer(0, 0, 0);               // zero previous: zero margin, counts as motion
		offer(-1, -1, -1);
		offer(-1, -1, -1);
		drain();

		// zero fraction: even an unchanged hand is motion
		write_reg(CFG_MARGIN_FRACTION, 16'h0000);
		@(negedge clk);
		repeat (3)
			offer(12345, -12345, 100);
		drain();

		// longest warm-up and widest margin/limit, then warm-up switched off
		write_reg(CFG_WARMUP_FRAMES, 16'hFFFF);
		write_reg(CFG_MARGIN_FRACTION, 16'hFFFF);
		write_reg(CFG_STILL_LIMIT, 16'hFFFF);
		@(negedge clk);
		repeat (4)
			offer(100, 200, 300);
		drain();
		write_reg(CFG_WARMUP_FRAMES, 16'h0000);
		@(negedge clk);
		repeat (4)
			offer(100, 200, 300);
		drain();

		// limit dropped to zero under a nonzero counter
		write_reg(CFG_STILL_LIMIT, 16'h0000);
		@(negedge clk);
		repeat (2)
			offer(100, 200, 300);
		drain();

		// random phases; the first runs without any idling
		gaps_on = 1'b0;
		random_phase(16'd0, 16'd3277, 16'd8);
		@(negedge clk);
		drain();
		gaps_on = 1'b1;

		random_phase(16'd0, 16'd6554, 16'd4);
		@(negedge clk);
		hold_req = 1'b1;
		drain();

		random_phase(16'd0, 16'hFFFF, 16'hFFFF);
		drain();
		random_phase(16'd0, 16'd0, 16'd5);
		drain();
		random_phase(16'd0, 16'd1000, 16'd0);
		drain();
		// a few warm-up frames left before detection resumes, random margin and limit
		repeat (2) begin
			random_phase(warm_seen + cfg_word_t'($urandom_range(12)),
				cfg_word_t'($urandom()), cfg_word_t'($urandom_range(20, 1)));
			drain();
		end

		repeat (8) @(posedge clk);
		if (errors == 0 && expect_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: hand_motion_stop_detector.f
design/hmsd_pkg.sv
design/hmsd_pos_if.sv
design/hmsd_res_if.sv
design/hmsd_axis.sv
design/hmsd_track.sv
design/hand_motion_stop_detector.sv
verif/hand_motion_stop_detector_tb.sv
